// ----- rtl/csvt_pkg.sv -----
// csv field tokenizer package: word types, state codes, character constants
// no dependencies; used by every rtl file of the tokenizer
`default_nettype none

package csvt_pkg;

  // special characters of the csv text
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;

  // result queue depth, power of two, at least 4
  localparam int unsigned ResultDepth = 4;

  typedef enum logic [2:0] {
    ST_ROW_START   = 3'd0,
    ST_FIELD_START = 3'd1,
    ST_UNQUOTED    = 3'd2,
    ST_QUOTED      = 3'd3,
    ST_QUOTE_SEEN  = 3'd4
  } csvt_state_t;

  typedef enum logic {
    KIND_DATA = 1'b0,
    KIND_EOI  = 1'b1
  } csvt_kind_t;

  typedef struct packed {
    logic       kind;
    logic [7:0] in_byte;
  } csvt_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       field_end;
    logic       row_end;
    logic       in_header;
    logic       last;
  } csvt_out_t;

  // everything one input word produces: up to two results and the next state
  typedef struct packed {
    logic [1:0]  count;
    csvt_out_t   res0;
    csvt_out_t   res1;
    csvt_state_t state_next;
    logic        first_row_next;
  } csvt_step_t;

  function automatic csvt_out_t mk_result(input logic [7:0] b, input logic bv,
                                          input logic fe, input logic re,
                                          input logic hdr);
    csvt_out_t r;
    r.out_byte   = bv ? b : 8'h00;
    r.byte_valid = bv;
    r.field_end  = fe;
    r.row_end    = re;
    r.in_header  = hdr;
    r.last       = 1'b0;
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/csvt_step.sv -----
// csv field tokenizer step logic: one input word and the current state
// give the results and the next state; depends on csvt_pkg
`default_nettype none

module csvt_step import csvt_pkg::*; (
  input  wire csvt_in_t    in_word,
  input  wire csvt_state_t parse_state,
  input  wire              first_row,
  output csvt_step_t       step
);

  logic [7:0] c;
  logic       is_eol;
  logic       is_comma;
  logic       is_quote;
  logic       do_begin;
  logic       do_close;

  assign c        = in_word.in_byte;
  assign is_eol   = (c == ChCr) || (c == ChLf);
  assign is_comma = (c == ChComma);
  assign is_quote = (c == ChQuote);

  always_comb begin
    step.count          = 2'd0;
    step.res0           = '0;
    step.res1           = '0;
    step.state_next     = parse_state;
    step.first_row_next = first_row;
    do_begin            = 1'b0;
    do_close            = 1'b0;

    if (in_word.kind == KIND_EOI) begin
      // flush: close an open field and row, then back to reset values
      if (parse_state == ST_FIELD_START) begin
        step.res0  = mk_result(8'h00, 1'b0, 1'b0, 1'b1, first_row);
        step.count = 2'd1;
      end else if (parse_state == ST_UNQUOTED || parse_state == ST_QUOTED ||
                   parse_state == ST_QUOTE_SEEN) begin
        step.res0  = mk_result(8'h00, 1'b0, 1'b1, 1'b1, first_row);
        step.count = 2'd1;
      end
      step.state_next     = ST_ROW_START;
      step.first_row_next = 1'b1;
    end else begin
      unique case (parse_state)
        ST_FIELD_START: begin
          do_begin = 1'b1;
        end
        ST_UNQUOTED: begin
          if (is_comma || is_eol) begin
            do_close = 1'b1;
          end else begin
            step.res0  = mk_result(c, 1'b1, 1'b0, 1'b0, first_row);
            step.count = 2'd1;
          end
        end
        ST_QUOTED: begin
          if (is_quote) begin
            step.state_next = ST_QUOTE_SEEN;
          end else begin
            step.res0  = mk_result(c, 1'b1, 1'b0, 1'b0, first_row);
            step.count = 2'd1;
          end
        end
        ST_QUOTE_SEEN: begin
          if (is_quote) begin
            // doubled quote
            step.res0       = mk_result(ChQuote, 1'b1, 1'b0, 1'b0, first_row);
            step.count      = 2'd1;
            step.state_next = ST_QUOTED;
          end else if (is_comma || is_eol) begin
            do_close = 1'b1;
          end else begin
            // text after closing quote opens a new unquoted field
            step.res0       = mk_result(8'h00, 1'b0, 1'b1, 1'b0, first_row);
            step.res1       = mk_result(c, 1'b1, 1'b0, 1'b0, first_row);
            step.count      = 2'd2;
            step.state_next = ST_UNQUOTED;
          end
        end
        default: begin
          // row start; blank lines skipped
          if (is_eol) begin
            step.state_next = ST_ROW_START;
          end else begin
            do_begin = 1'b1;
          end
        end
      endcase

      if (do_begin) begin
        if (is_eol) begin
          // trailing comma: row end only
          step.res0           = mk_result(8'h00, 1'b0, 1'b0, 1'b1, first_row);
          step.count          = 2'd1;
          step.first_row_next = 1'b0;
          step.state_next     = ST_ROW_START;
        end else if (is_quote) begin
          step.state_next = ST_QUOTED;
        end else if (is_comma) begin
          step.res0       = mk_result(8'h00, 1'b0, 1'b1, 1'b0, first_row);
          step.count      = 2'd1;
          step.state_next = ST_FIELD_START;
        end else begin
          step.res0       = mk_result(c, 1'b1, 1'b0, 1'b0, first_row);
          step.count      = 2'd1;
          step.state_next = ST_UNQUOTED;
        end
      end

      if (do_close) begin
        step.count = 2'd1;
        if (is_comma) begin
          step.res0       = mk_result(8'h00, 1'b0, 1'b1, 1'b0, first_row);
          step.state_next = ST_FIELD_START;
        end else begin
          step.res0           = mk_result(8'h00, 1'b0, 1'b1, 1'b1, first_row);
          step.first_row_next = 1'b0;
          step.state_next     = ST_ROW_START;
        end
      end
    end

    if (step.count == 2'd1) begin
      step.res0.last = 1'b1;
    end
    if (step.count == 2'd2) begin
      step.res1.last = 1'b1;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/csvt_result_fifo.sv -----
// csv field tokenizer result queue: takes up to two results a cycle,
// hands out one a cycle while out_ready is high; depends on csvt_pkg
`default_nettype none

module csvt_result_fifo import csvt_pkg::*; #(
  parameter int unsigned Depth = ResultDepth
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         push,
  input  wire         csvt_step_t step,
  output logic        has_room,
  output logic        out_valid,
  input  wire         out_ready,
  output csvt_out_t   out_word
);

  localparam int unsigned PW = $clog2(Depth);
  localparam int unsigned CW = $clog2(Depth + 1);

  csvt_out_t       mem [Depth];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   wr_ptr1;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   level;
  logic [1:0]      n;
  logic            pop;

  assign n        = push ? step.count : 2'd0;
  assign pop      = out_valid && out_ready;
  assign wr_ptr1  = wr_ptr + PW'(1);
  assign has_room = (level <= CW'(Depth - 2));
  assign out_valid = (level != '0);
  assign out_word  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(n);
      rd_ptr <= rd_ptr + PW'(pop);
      level  <= level + CW'(n) - CW'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (n != 2'd0) begin
      mem[wr_ptr] <= step.res0;
    end
    if (n == 2'd2) begin
      mem[wr_ptr1] <= step.res1;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/csvt_result_fifo_dummy_placeholder.sv -----
// csv field tokenizer: no extra logic in this file beyond a registered
// pass counter check helper; depends on csvt_pkg
`default_nettype none

module csvt_word_count import csvt_pkg::*; (
  input  wire        clk,
  input  wire        rst,
  input  wire        in_acc,
  input  wire        out_acc,
  output logic [1:0] in_parity,
  output logic [1:0] out_parity
);

  // running two-bit counts of accepted input and output words
  always_ff @(posedge clk) begin
    if (rst) begin
      in_parity  <= 2'd0;
      out_parity <= 2'd0;
    end else begin
      in_parity  <= in_parity + {1'b0, in_acc};
      out_parity <= out_parity + {1'b0, out_acc};
    end
  end

endmodule

`default_nettype wire

// ----- rtl/csv_field_tokenizer_core.sv -----
// csv field tokenizer top level: state register, step logic, result queue
// depends on csvt_pkg, csvt_step, csvt_result_fifo, csvt_word_count
// results are offered from the registered result queue, not straight from the step logic
// throughput: one input word per cycle while the queue has room; a word after a
//   closing quote that opens a new field yields two results and the
//   one-result-per-cycle output port sets the sustained rate then
// reset: synchronous rst puts the parser at row start with the header flag set
//   and empties the result queue; no clearing pass
`default_nettype none

module csv_field_tokenizer_core import csvt_pkg::*; #(
  parameter int unsigned Depth = ResultDepth  // result queue depth, power of two, >= 4
) (
  input  wire        clk,
  input  wire        rst,
  input  wire        in_valid,
  output logic       in_ready,
  input  wire        csvt_in_t in_word,
  output logic       out_valid,
  input  wire        out_ready,
  output csvt_out_t  out_word
);

  // parser state
  csvt_state_t parse_state;
  logic        first_row;

  csvt_step_t  step;
  logic        in_acc;
  logic        out_acc;
  logic [1:0]  in_parity;
  logic [1:0]  out_parity;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // combinational step: whole work for one word happens here
  csvt_step u_step (
    .in_word     (in_word),
    .parse_state (parse_state),
    .first_row   (first_row),
    .step        (step)
  );

  // state register only moves on an accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      parse_state <= ST_ROW_START;
      first_row   <= 1'b1;
    end else if (in_acc) begin
      parse_state <= step.state_next;
      first_row   <= step.first_row_next;
    end
  end

  // results go into a small queue; input stays open while two slots are free,
  // so a waiting output never blocks the next byte by itself
  csvt_result_fifo #(
    .Depth (Depth)
  ) u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (in_acc),
    .step      (step),
    .has_room  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_word  (out_word)
  );

  // accepted word counters, watched by the checks below
  csvt_word_count u_count (
    .clk        (clk),
    .rst        (rst),
    .in_acc     (in_acc),
    .out_acc    (out_acc),
    .in_parity  (in_parity),
    .out_parity (out_parity)
  );

`ifndef SYNTHESIS
  // end of input always leaves the parser at its reset values
  a_eoi_resets: assert property (@(posedge clk) disable iff (rst)
    in_acc && (in_word.kind == KIND_EOI) |=>
      (parse_state == ST_ROW_START) && first_row)
    else $error("end of input did not reset parser");

  // two results only come from text after a closing quote
  a_two_results: assert property (@(posedge clk) disable iff (rst)
    in_acc && (step.count == 2'd2) |-> (parse_state == ST_QUOTE_SEEN))
    else $error("two results outside quote-seen state");

  // blank line bytes at row start are dropped silently
  a_blank_skip: assert property (@(posedge clk) disable iff (rst)
    in_acc && (in_word.kind == KIND_DATA) && (parse_state == ST_ROW_START) &&
    ((in_word.in_byte == ChCr) || (in_word.in_byte == ChLf))
      |-> (step.count == 2'd0))
    else $error("result produced for blank line byte");

  // the counters step by one per accepted word; checked: they hold when no word is accepted
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !in_acc && !out_acc |=> $stable(in_parity) && $stable(out_parity))
    else $error("word counters moved without a handshake");
`endif

endmodule

`default_nettype wire

// ----- test/tb_csv_field_tokenizer_core.sv -----
// testbench for csv_field_tokenizer_core: random and directed csv byte streams,
// exact result prediction, idle and stall phases; depends on csvt_pkg and the rtl
`timescale 1ns / 100ps

module tb_csv_field_tokenizer_core;
  import csvt_pkg::*;

  localparam int StallLimit = 4000;  // cycles with no word moving while work is open
  localparam int NumPhases  = 5;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  csvt_in_t  in_word = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  csvt_out_t out_word;

  csv_field_tokenizer_core dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word (out_word)
  );

  always #5 clk = ~clk;

  csvt_in_t    csv_bytes_pending[$];
  csvt_out_t   tokens_expected[$];

  // tokenizer state as the testbench sees it
  csvt_state_t tok_state  = ST_ROW_START;
  logic        tok_header = 1'b1;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int err_count      = 0;
  int stall_cycles   = 0;
  int fed_count      = 0;

  // ---------------------------------------------------------------- prediction

  function automatic logic is_eol(logic [7:0] c);
    return (c == ChCr) || (c == ChLf);
  endfunction

  task automatic push_token(logic [7:0] b, logic bv, logic fe, logic re);
    csvt_out_t r;
    r.out_byte   = bv ? b : 8'h00;
    r.byte_valid = bv;
    r.field_end  = fe;
    r.row_end    = re;
    r.in_header  = tok_header;
    r.last       = 1'b0;
    tokens_expected.insert(tokens_expected.size(), r);
  endtask

  // first byte of a field, at row start or after a comma
  task automatic open_field(logic [7:0] c);
    if (is_eol(c)) begin
      push_token(8'h00, 1'b0, 1'b0, 1'b1);
      tok_header = 1'b0;
      tok_state  = ST_ROW_START;
    end else if (c == ChQuote) begin
      tok_state = ST_QUOTED;
    end else if (c == ChComma) begin
      push_token(8'h00, 1'b0, 1'b1, 1'b0);
      tok_state = ST_FIELD_START;
    end else begin
      push_token(c, 1'b1, 1'b0, 1'b0);
      tok_state = ST_UNQUOTED;
    end
  endtask

  // separator closes the open field
  task automatic close_field(logic [7:0] c);
    if (c == ChComma) begin
      push_token(8'h00, 1'b0, 1'b1, 1'b0);
      tok_state = ST_FIELD_START;
    end else begin
      push_token(8'h00, 1'b0, 1'b1, 1'b1);
      tok_header = 1'b0;
      tok_state  = ST_ROW_START;
    end
  endtask

  task automatic tokenize_word(csvt_in_t w);
    int base;
    logic [7:0] c;
    base = tokens_expected.size();
    c    = w.in_byte;
    if (w.kind == KIND_EOI) begin
      case (tok_state)
        ST_FIELD_START: push_token(8'h00, 1'b0, 1'b0, 1'b1);
        ST_UNQUOTED, ST_QUOTED, ST_QUOTE_SEEN: push_token(8'h00, 1'b0, 1'b1, 1'b1);
        default: ;
      endcase
      tok_state  = ST_ROW_START;
      tok_header = 1'b1;
    end else begin
      case (tok_state)
        ST_FIELD_START: open_field(c);
        ST_UNQUOTED: begin
          if (c == ChComma || is_eol(c)) close_field(c);
          else push_token(c, 1'b1, 1'b0, 1'b0);
        end
        ST_QUOTED: begin
          if (c == ChQuote) tok_state = ST_QUOTE_SEEN;
          else push_token(c, 1'b1, 1'b0, 1'b0);
        end
        ST_QUOTE_SEEN: begin
          if (c == ChQuote) begin
            push_token(ChQuote, 1'b1, 1'b0, 1'b0);
            tok_state = ST_QUOTED;
          end else if (c == ChComma || is_eol(c)) begin
            close_field(c);
          end else begin
            // text after the closing quote starts a new unquoted field
            push_token(8'h00, 1'b0, 1'b1, 1'b0);
            push_token(c, 1'b1, 1'b0, 1'b0);
            tok_state = ST_UNQUOTED;
          end
        end
        default: begin
          if (is_eol(c)) tok_state = ST_ROW_START;  // blank line
          else open_field(c);
        end
      endcase
    end
    if (tokens_expected.size() > base)
      tokens_expected[tokens_expected.size() - 1].last = 1'b1;
  endtask

  // ---------------------------------------------------------------- stimulus

  task automatic add_byte(logic [7:0] b);
    csvt_in_t w;
    w.kind    = KIND_DATA;
    w.in_byte = b;
    csv_bytes_pending.insert(csv_bytes_pending.size(), w);
    fed_count++;
  endtask

  // line-end bytes the parser skips, not counted as work
  task automatic add_skip(logic [7:0] b);
    csvt_in_t w;
    w.kind    = KIND_DATA;
    w.in_byte = b;
    csv_bytes_pending.insert(csv_bytes_pending.size(), w);
  endtask

  task automatic add_eoi();
    csvt_in_t w;
    w.kind    = KIND_EOI;
    w.in_byte = 8'($urandom_range(255));
    csv_bytes_pending.insert(csv_bytes_pending.size(), w);
    fed_count++;
  endtask

  function automatic logic [7:0] text_char();
    case ($urandom_range(9))
      6, 7:    return 8'($urandom_range(255));
      8:       return ChQuote;
      9:       return 8'("0") + 8'($urandom_range(9));
      default: return 8'("a") + 8'($urandom_range(25));
    endcase
  endfunction

  task automatic add_field();
    int n;
    logic [7:0] c;
    n = $urandom_range(4);
    if ($urandom_range(1) == 1) begin
      add_byte(ChQuote);
      repeat (n) begin
        case ($urandom_range(7))
          0:       c = ChComma;
          1:       c = ChCr;
          2:       c = ChLf;
          3:       c = ChQuote;
          default: c = text_char();
        endcase
        add_byte(c);
        if (c == ChQuote) add_byte(ChQuote);
      end
      add_byte(ChQuote);
      if ($urandom_range(15) == 0) add_byte(8'("a") + 8'($urandom_range(25)));
    end else begin
      repeat (n) begin
        c = text_char();
        if (c == ChComma || is_eol(c)) c = 8'("_");
        add_byte(c);
      end
    end
  endtask

  task automatic add_row();
    int nf;
    nf = $urandom_range(1, 4);
    for (int i = 0; i < nf; i++) begin
      if (i > 0) add_byte(ChComma);
      add_field();
    end
    if ($urandom_range(9) == 0) add_byte(ChComma);  // trailing comma
    if ($urandom_range(11) == 0) begin
      add_eoi();  // stream cut inside the row
    end else begin
      case ($urandom_range(3))
        0: add_byte(ChCr);
        1: add_byte(ChLf);
        2: begin
          add_byte(ChCr);
          add_skip(ChLf);
        end
        default: begin
          add_byte(ChCr);
          add_skip(ChLf);
          add_skip(ChLf);
        end
      endcase
    end
  endtask

  task automatic add_noise();
    repeat ($urandom_range(1, 6)) begin
      case ($urandom_range(3))
        0: add_byte(ChQuote);
        1: add_byte(ChComma);
        2: add_byte($urandom_range(1) ? ChCr : ChLf);
        default: add_byte(8'($urandom_range(255)));
      endcase
    end
  endtask

  task automatic gen_random(int n);
    int target;
    target = fed_count + n;
    while (fed_count < target) begin
      case ($urandom_range(19))
        15, 16, 17: add_noise();
        18, 19:     add_eoi();
        default:    add_row();
      endcase
    end
  endtask

  task automatic add_directed();
    // header row: doubled quote, comma and 0xff inside quotes, trailing comma
    add_byte(8'("a"));
    add_byte(ChComma);
    add_byte(ChQuote);
    add_byte(ChQuote);
    add_byte(ChQuote);
    add_byte(ChComma);
    add_byte(8'hFF);
    add_byte(ChQuote);
    add_byte(ChComma);
    add_byte(ChCr);
    add_byte(ChLf);     // blank line skipped
    // empty leading field, lf as data, text after closing quote
    add_byte(ChComma);
    add_byte(ChQuote);
    add_byte(ChLf);
    add_byte(ChQuote);
    add_byte(8'h00);
    add_byte(ChQuote);  // quote inside an unquoted field is data
    add_byte(ChCr);
    add_byte(8'h80);
    add_eoi();          // closes field and row
    add_eoi();          // nothing open
    add_byte(ChComma);  // header row again after end of input
    add_eoi();          // trailing comma at end of input
    add_byte(ChQuote);
    add_eoi();          // unterminated quoted field
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (csv_bytes_pending.size() != 0 || in_valid || tokens_expected.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  // ---------------------------------------------------------------- sender

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_word  <= '0;
    end else if (!in_valid || in_ready) begin
      if (in_valid) tokenize_word(in_word);
      if (csv_bytes_pending.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_word  <= csv_bytes_pending.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- receiver

  always @(posedge clk) begin : rx_side
    csvt_out_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (tokens_expected.size() == 0) begin
          $error("unexpected word: out_byte %02h byte_valid %0b field_end %0b row_end %0b",
                 out_word.out_byte, out_word.byte_valid, out_word.field_end,
                 out_word.row_end);
          err_count++;
        end else begin
          want = tokens_expected.pop_front();
          if (out_word.out_byte !== want.out_byte) begin
            $error("out_byte: expected %02h, got %02h", want.out_byte, out_word.out_byte);
            err_count++;
          end
          if (out_word.byte_valid !== want.byte_valid) begin
            $error("byte_valid: expected %0b, got %0b", want.byte_valid,
                   out_word.byte_valid);
            err_count++;
          end
          if (out_word.field_end !== want.field_end) begin
            $error("field_end: expected %0b, got %0b", want.field_end, out_word.field_end);
            err_count++;
          end
          if (out_word.row_end !== want.row_end) begin
            $error("row_end: expected %0b, got %0b", want.row_end, out_word.row_end);
            err_count++;
          end
          if (out_word.in_header !== want.in_header) begin
            $error("in_header: expected %0b, got %0b", want.in_header,
                   out_word.in_header);
            err_count++;
          end
          if (out_word.last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, out_word.last);
            err_count++;
          end
        end
      end
      out_ready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) ||
        (csv_bytes_pending.size() == 0 && !in_valid && tokens_expected.size() == 0)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- sequence

  int idle_by_phase[NumPhases]  = '{0, 81, 0, 22, 0};
  int stall_by_phase[NumPhases] = '{0, 0, 81, 22, 0};

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    for (int p = 0; p < NumPhases; p++) begin
      @(negedge clk);
      send_idle_pct  = idle_by_phase[p];
      recv_stall_pct = stall_by_phase[p];
      if (p == 0) add_directed();
      gen_random(160);
      // next phase waits until every queued byte is sent and every expected word is back
      wait_drained();
    end
    repeat (8) @(negedge clk);
    if (err_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
